@@ sv/scfl_pkg.sv @@
`default_nettype none
package scfl_pkg;

    // request codes
    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_REALLOC = 2'd2
    } t_kind;

    // result codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_LARGE = 2'd1,
        STAT_OOM   = 2'd2
    } t_status;

    // refill attempts per allocate before giving up
    localparam logic [1:0] PASS_LIMIT = 2'd3;
    // a new pool adds heap_used >> HEAP_SHIFT bytes of slack
    localparam int HEAP_SHIFT = 4;
    // a new pool is GROW_SHIFT powers of two times the chunk size
    localparam int GROW_SHIFT = 1;

endpackage
`default_nettype wire

@@ sv/scfl_in_if.sv @@
`default_nettype none
interface scfl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] req_size;
    logic [11:0] old_size;
    logic [15:0] block_addr;

    modport source (output valid, kind, req_size, old_size, block_addr, input ready);
    modport sink   (input valid, kind, req_size, old_size, block_addr, output ready);
endinterface
`default_nettype wire

@@ sv/scfl_out_if.sv @@
`default_nettype none
interface scfl_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_addr;
    logic [1:0]  status;

    modport source (output valid, result_addr, status, input ready);
    modport sink   (input valid, result_addr, status, output ready);
endinterface
`default_nettype wire

@@ sv/scfl_ram.sv @@
`default_nettype none
module scfl_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

@@ sv/size_class_free_list_allocator_core.sv @@
// Small-block allocator with segregated LIFO free lists, one per granule size
// class, over a fixed arena. Each item is an allocate, a free, a realloc or an
// unused code and gives one result (address and status). Items are handled one
// at a time by a sequencer around a shared adder and a link RAM holding one next
// pointer per granule. A free, an oversized request or an unused code is settled
// in decode, and an allocate that hits its list pops the head. An allocate that
// misses carves its blocks from the pool, first taking a new pool from the arena
// when needed; when the pool only partly covers the chunk, repeated subtraction
// first counts the whole blocks that fit. When the arena is exhausted, the scan
// checks the size classes in turn, pops a larger free block as the pool and
// checks again. The result sits in an output register; the next item is taken
// once it is delivered or as it is taken. The link RAM is not cleared after
// reset: entries are written before they are read.
`default_nettype none
module size_class_free_list_allocator_core #(
    parameter int ALIGN_BYTES     = 8,
    parameter int MAX_SMALL_BYTES = 128,
    parameter int NUM_CLASSES     = 16,
    parameter int ARENA_BYTES     = 65536,
    parameter int CHUNK_OBJECTS   = 20
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    scfl_in_if.sink   i_in,
    scfl_out_if.source o_out
);
    import scfl_pkg::*;

    localparam int AS    = $clog2(ALIGN_BYTES);
    localparam int AW    = $clog2(ARENA_BYTES) + 1;
    localparam int XW    = AW + 2;
    localparam int DEPTH = ARENA_BYTES / ALIGN_BYTES;
    localparam int GW    = $clog2(DEPTH);
    localparam int CW    = $clog2(NUM_CLASSES);
    localparam int NW    = $clog2(CHUNK_OBJECTS + 1);
    localparam int LW    = AW + 1;

    localparam logic [XW-1:0] ALIGN_X = XW'(ALIGN_BYTES);
    localparam logic [XW-1:0] MAX_X   = XW'(MAX_SMALL_BYTES);
    localparam logic [XW-1:0] NUMC_X  = XW'(NUM_CLASSES);
    localparam logic [XW-1:0] ARENA_X = XW'(ARENA_BYTES);
    localparam logic [XW-1:0] LIMIT_X = XW'(DEPTH * ALIGN_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_ALLOC, ST_POP_DATA, ST_MUL,
        ST_CHK, ST_DIV, ST_REFILL, ST_SCAN, ST_CARVE
    } t_state;

    function automatic logic [XW-1:0] align_up(input logic [XW-1:0] x);
        align_up = (x + ALIGN_X - XW'(1)) & ~(ALIGN_X - XW'(1));
    endfunction

    function automatic logic [XW-1:0] class_of(input logic [XW-1:0] x);
        class_of = ((x + ALIGN_X - XW'(1)) >> AS) - XW'(1);
    endfunction

    function automatic logic is_small(input logic [XW-1:0] x);
        is_small = (x <= MAX_X) && (class_of(x) < NUMC_X);
    endfunction

    t_state         r_state;
    t_kind          r_kind;
    logic [11:0]    r_req;
    logic [11:0]    r_old;
    logic [15:0]    r_addr;
    logic           r_out_valid;
    logic [15:0]    r_res;
    t_status        r_stat;
    logic [AW-1:0]  r_head [NUM_CLASSES];
    logic           r_hval [NUM_CLASSES];
    logic [XW-1:0]  r_pstart;
    logic [XW-1:0]  r_pend;
    logic [XW-1:0]  r_heap;
    logic [CW-1:0]  r_cls;
    logic [XW-1:0]  r_sz;
    logic [NW-1:0]  r_nobjs;
    logic [NW-1:0]  r_k;
    logic [NW-1:0]  r_q;
    logic [XW-1:0]  r_total;
    logic [XW-1:0]  r_rem;
    logic [XW-1:0]  r_b;
    logic [XW-1:0]  r_chunk;
    logic [XW-1:0]  r_scan;
    logic [1:0]     r_pass;
    logic           r_pop_scan;
    logic           r_pop_oob;
    logic [CW-1:0]  r_pop_cls;
    logic [AW-1:0]  r_pop_a;

    logic [XW-1:0]  req_n, old_n, left, get, n_sum, alu_a, alu_b;
    logic           alu_sub;
    logic           req_small, old_small, dec_push, rem_push, scan_in, grow_ok;
    logic [CW-1:0]  dec_cls, rem_cls, pop_cls;
    logic [AW-1:0]  pop_a;
    logic           wr_en;
    logic [GW-1:0]  wr_gran, rd_gran;
    logic [LW-1:0]  wr_data, rd_data;

    // request decode
    assign req_n     = (r_req == 12'd0) ? XW'(1) : XW'(r_req);
    assign old_n     = (r_old == 12'd0) ? XW'(1) : XW'(r_old);
    assign req_small = is_small(req_n);
    assign old_small = is_small(old_n);
    assign dec_cls   = (r_kind == KIND_FREE) ? CW'(class_of(req_n)) : CW'(class_of(old_n));
    assign dec_push  = ((r_kind == KIND_FREE && req_small) ||
                        (r_kind == KIND_REALLOC && req_small && old_small)) &&
                       (r_addr[AS-1:0] == '0) && (XW'(r_addr) < LIMIT_X);

    // pool bookkeeping
    assign left     = r_pend - r_pstart;
    assign rem_cls  = CW'(class_of(left));
    assign rem_push = (left != '0) && (class_of(left) < NUMC_X) && (r_pstart < LIMIT_X);
    assign get      = (r_total << GROW_SHIFT) + align_up(r_heap >> HEAP_SHIFT);
    assign grow_ok  = (r_heap <= ARENA_X) && (get <= ARENA_X - r_heap);
    assign scan_in  = is_small(r_scan);

    // list pop address
    assign pop_cls = (r_state == ST_SCAN) ? CW'(class_of(r_scan)) : r_cls;
    assign pop_a   = r_head[pop_cls];
    assign rd_gran = GW'(XW'(pop_a) >> AS);

    // shared adder
    assign n_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + XW'(alu_sub);

    // link RAM write port and adder operand select
    always_comb begin
        wr_en   = 1'b0;
        wr_gran = '0;
        wr_data = '0;
        alu_a   = r_b;
        alu_b   = r_sz;
        alu_sub = 1'b0;
        case (r_state)
            ST_DECODE: begin
                wr_en   = dec_push;
                wr_gran = GW'(XW'(r_addr) >> AS);
                wr_data = {r_hval[dec_cls], r_head[dec_cls]};
            end
            ST_CHK: begin
                wr_en   = (r_pass != PASS_LIMIT) && (left < r_total) && (left < r_sz) &&
                          rem_push;
                wr_gran = GW'(r_pstart >> AS);
                wr_data = {r_hval[rem_cls], r_head[rem_cls]};
            end
            ST_CARVE: begin
                wr_en   = (r_k < r_nobjs) && (r_b < LIMIT_X);
                wr_gran = GW'(r_b >> AS);
                wr_data = {(NW'(r_k + NW'(1)) < r_nobjs), AW'(n_sum)};
            end
            ST_DIV: begin
                alu_a   = r_rem;
                alu_sub = 1'b1;
            end
            ST_SCAN: begin
                alu_a = r_scan;
                alu_b = ALIGN_X;
            end
            ST_REFILL: begin
                alu_a = r_heap;
                alu_b = get;
            end
            ST_POP_DATA: begin
                alu_a = XW'(r_pop_a);
                alu_b = r_scan;
            end
            default: begin
            end
        endcase
    end

    scfl_ram #(
        .WIDTH (LW),
        .DEPTH (2 ** GW)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_gran),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_gran),
        .o_rd_data (rd_data)
    );

    assign i_in.ready        = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign o_out.valid       = r_out_valid;
    assign o_out.result_addr = r_res;
    assign o_out.status      = r_stat;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pstart    <= '0;
            r_pend      <= '0;
            r_heap      <= '0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_hval[c] <= 1'b0;
            end
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_kind  <= t_kind'(i_in.kind);
                        r_req   <= i_in.req_size;
                        r_old   <= i_in.old_size;
                        r_addr  <= i_in.block_addr;
                        r_state <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    r_cls <= CW'(class_of(req_n));
                    r_sz  <= align_up(req_n);
                    if (dec_push) begin
                        r_head[dec_cls] <= AW'(r_addr);
                        r_hval[dec_cls] <= 1'b1;
                    end
                    case (r_kind)
                        KIND_ALLOC: begin
                            if (req_small) begin
                                r_state <= ST_ALLOC;
                            end else begin
                                r_out_valid <= 1'b1;
                                r_res       <= '0;
                                r_stat      <= STAT_LARGE;
                                r_state     <= ST_IDLE;
                            end
                        end
                        KIND_REALLOC: begin
                            if (req_small && old_small) begin
                                r_state <= ST_ALLOC;
                            end else begin
                                r_out_valid <= 1'b1;
                                r_res       <= '0;
                                r_stat      <= STAT_LARGE;
                                r_state     <= ST_IDLE;
                            end
                        end
                        KIND_FREE: begin
                            r_out_valid <= 1'b1;
                            r_res       <= '0;
                            r_stat      <= req_small ? STAT_OK : STAT_LARGE;
                            r_state     <= ST_IDLE;
                        end
                        default: begin
                            r_out_valid <= 1'b1;
                            r_res       <= '0;
                            r_stat      <= STAT_OK;
                            r_state     <= ST_IDLE;
                        end
                    endcase
                end
                ST_ALLOC: begin
                    if (r_hval[r_cls]) begin
                        r_pop_scan <= 1'b0;
                        r_pop_cls  <= r_cls;
                        r_pop_a    <= pop_a;
                        r_pop_oob  <= XW'(pop_a) >= LIMIT_X;
                        r_state    <= ST_POP_DATA;
                    end else begin
                        r_nobjs <= NW'(CHUNK_OBJECTS);
                        r_pass  <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_POP_DATA: begin
                    if (r_pop_oob) begin
                        r_hval[r_pop_cls] <= 1'b0;
                    end else begin
                        r_head[r_pop_cls] <= rd_data[AW-1:0];
                        r_hval[r_pop_cls] <= rd_data[AW];
                    end
                    if (r_pop_scan) begin
                        // the larger free block becomes the pool
                        r_pstart <= XW'(r_pop_a);
                        r_pend   <= n_sum;
                        r_pass   <= r_pass + 2'd1;
                        r_state  <= ST_CHK;
                    end else begin
                        r_out_valid <= 1'b1;
                        r_res       <= 16'(r_pop_a);
                        r_stat      <= STAT_OK;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_MUL: begin
                    r_total <= XW'(r_sz * XW'(r_nobjs));
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (r_pass == PASS_LIMIT) begin
                        r_out_valid <= 1'b1;
                        r_res       <= '0;
                        r_stat      <= STAT_OOM;
                        r_state     <= ST_IDLE;
                    end else if (left >= r_total) begin
                        r_chunk  <= r_pstart;
                        r_b      <= r_pstart + r_sz;
                        r_k      <= NW'(1);
                        r_pstart <= r_pstart + r_total;
                        r_state  <= ST_CARVE;
                    end else if (left >= r_sz) begin
                        r_rem   <= left;
                        r_q     <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        // leftover pool goes onto the list of its size
                        if (rem_push) begin
                            r_head[rem_cls] <= AW'(r_pstart);
                            r_hval[rem_cls] <= 1'b1;
                        end
                        r_state <= ST_REFILL;
                    end
                end
                ST_DIV: begin
                    // count whole blocks left in the pool
                    if (r_rem >= r_sz) begin
                        r_rem <= n_sum;
                        r_q   <= r_q + NW'(1);
                    end else begin
                        r_nobjs  <= r_q;
                        r_chunk  <= r_pstart;
                        r_b      <= r_pstart + r_sz;
                        r_k      <= NW'(1);
                        r_pstart <= r_pend - r_rem;
                        r_state  <= ST_CARVE;
                    end
                end
                ST_REFILL: begin
                    if (grow_ok) begin
                        r_pstart <= r_heap;
                        r_heap   <= n_sum;
                        r_pend   <= n_sum;
                        r_pass   <= r_pass + 2'd1;
                        r_state  <= ST_CHK;
                    end else begin
                        r_scan  <= r_sz;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (!scan_in) begin
                        r_pstart    <= '0;
                        r_pend      <= '0;
                        r_out_valid <= 1'b1;
                        r_res       <= '0;
                        r_stat      <= STAT_OOM;
                        r_state     <= ST_IDLE;
                    end else if (r_hval[pop_cls]) begin
                        r_pop_scan <= 1'b1;
                        r_pop_cls  <= pop_cls;
                        r_pop_a    <= pop_a;
                        r_pop_oob  <= XW'(pop_a) >= LIMIT_X;
                        r_state    <= ST_POP_DATA;
                    end else begin
                        r_scan <= n_sum;
                    end
                end
                ST_CARVE: begin
                    // link the extra blocks one per cycle
                    if (r_k < r_nobjs) begin
                        r_b <= n_sum;
                        r_k <= r_k + NW'(1);
                    end else begin
                        if (r_nobjs > NW'(1)) begin
                            r_head[r_cls] <= AW'(r_chunk + r_sz);
                            r_hval[r_cls] <= 1'b1;
                        end
                        r_out_valid <= 1'b1;
                        r_res       <= 16'(r_chunk);
                        r_stat      <= STAT_OK;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // a result only appears at the end of an item's work
    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) != ST_IDLE)
        else $error("result raised without an item in progress");

    // no item is taken while the sequencer is busy
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (r_state == ST_IDLE))
        else $error("ready while busy");

    // the carve counter never runs past the block count
    a_carve_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CARVE) |-> (r_k <= r_nobjs || r_nobjs == '0))
        else $error("carve counter overran");

    // a pop always returns to the refill check or ends the item
    a_pop_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP_DATA) |=> (r_state == ST_CHK || r_state == ST_IDLE))
        else $error("bad step after list pop");

endmodule
`default_nettype wire

@@ bench/size_class_free_list_allocator_core_tb.sv @@
`default_nettype none
module size_class_free_list_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import scfl_pkg::*;

    localparam int unsigned GRAN      = 8;
    localparam int unsigned SMALL_MAX = 128;
    localparam int unsigned CLASSES   = 16;
    localparam int unsigned ARENA     = 65536;
    localparam int unsigned CHUNK     = 20;
    localparam int unsigned LINKS     = ARENA / GRAN;
    localparam logic [1:0]  KIND_NONE = 2'd3;   // unused request code

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  status;
    } t_grant;

    typedef struct {
        logic [15:0] addr;
        logic [11:0] size;
    } t_block;

    // Allocator mirror plus the queue of grants still owed by the block
    class alloc_scoreboard;
        int unsigned head_addr [CLASSES];
        bit          head_ok   [CLASSES];
        int unsigned link_addr [LINKS];
        bit          link_ok   [LINKS];
        int unsigned pool_lo, pool_hi, heap_top;
        t_grant      owed[$];
        int          errors;

        function new();
            foreach (head_ok[i]) begin
                head_addr[i] = 0;
                head_ok[i] = 0;
            end
            foreach (link_ok[i]) begin
                link_addr[i] = 0;
                link_ok[i] = 0;
            end
            pool_lo = 0;
            pool_hi = 0;
            heap_top = 0;
            errors = 0;
        endfunction

        function int unsigned granules_up(int unsigned n);
            return (n + GRAN - 1) / GRAN * GRAN;
        endfunction

        function int unsigned class_for(int unsigned n);
            return (n + GRAN - 1) / GRAN - 1;
        endfunction

        function bit fits_small(int unsigned n);
            return n <= SMALL_MAX && class_for(n) < CLASSES;
        endfunction

        function void write_link(int unsigned a, int unsigned nxt, bit ok);
            if (a / GRAN < LINKS) begin
                link_addr[a / GRAN] = nxt;
                link_ok[a / GRAN] = ok;
            end
        endfunction

        function void push_free(int unsigned c, int unsigned a);
            if (c >= CLASSES || a / GRAN >= LINKS) return;
            write_link(a, head_addr[c], head_ok[c]);
            head_addr[c] = a;
            head_ok[c] = 1;
        endfunction

        function bit pop_free(int unsigned c, output int unsigned a);
            a = 0;
            if (c >= CLASSES || !head_ok[c]) return 0;
            a = head_addr[c];
            if (a / GRAN < LINKS) begin
                head_addr[c] = link_addr[a / GRAN];
                head_ok[c] = link_ok[a / GRAN];
            end else begin
                head_ok[c] = 0;
            end
            return 1;
        endfunction

        // pool refill: bump pool, then arena, then a larger free block
        function bit carve_pool(int unsigned sz, inout int unsigned nobjs,
                                output int unsigned a);
            int unsigned total, left, grab, probe, b;
            bit hit;
            a = 0;
            for (int pass = 0; pass < 3; pass++) begin
                total = sz * nobjs;
                left = pool_hi - pool_lo;
                hit = 0;
                if (left >= total) begin
                    a = pool_lo;
                    pool_lo += total;
                    return 1;
                end
                if (left >= sz) begin
                    nobjs = left / sz;
                    a = pool_lo;
                    pool_lo += nobjs * sz;
                    return 1;
                end
                if (left > 0) push_free(class_for(left), pool_lo);
                grab = 2 * total + granules_up(heap_top >> 4);
                if (heap_top <= ARENA && grab <= ARENA - heap_top) begin
                    pool_lo = heap_top;
                    heap_top += grab;
                    pool_hi = pool_lo + grab;
                    continue;
                end
                for (probe = sz; probe <= SMALL_MAX && class_for(probe) < CLASSES;
                     probe += GRAN) begin
                    if (pop_free(class_for(probe), b)) begin
                        pool_lo = b;
                        pool_hi = b + probe;
                        hit = 1;
                        break;
                    end
                end
                if (!hit) begin
                    pool_lo = 0;
                    pool_hi = 0;
                    return 0;
                end
            end
            return 0;
        endfunction

        function t_status grant_block(int unsigned n, output int unsigned a);
            int unsigned c, sz, nobjs, base, b;
            a = 0;
            if (n == 0) n = 1;
            if (!fits_small(n)) return STAT_LARGE;
            c = class_for(n);
            if (pop_free(c, a)) return STAT_OK;
            sz = granules_up(n);
            nobjs = CHUNK;
            if (!carve_pool(sz, nobjs, base)) return STAT_OOM;
            a = base;
            if (nobjs > 1) begin
                for (int unsigned k = 1; k < nobjs; k++) begin
                    b = base + k * sz;
                    write_link(b, b + sz, k + 1 < nobjs);
                end
                head_addr[c] = base + sz;
                head_ok[c] = 1;
            end
            return STAT_OK;
        endfunction

        function void release_block(int unsigned a, int unsigned n);
            if (n == 0) n = 1;
            if (a % GRAN != 0 || a >= ARENA) return;
            push_free(class_for(n), a);
        endfunction

        // accepted request: update the mirror and queue the grant it owes
        function t_grant note_request(logic [1:0] kind, logic [11:0] req,
                                      logic [11:0] old, logic [15:0] addr);
            int unsigned a;
            t_status st;
            t_grant g;
            a = 0;
            st = STAT_OK;
            case (kind)
                KIND_ALLOC: st = grant_block(req, a);
                KIND_FREE: begin
                    if (!fits_small(req == 0 ? 1 : req)) st = STAT_LARGE;
                    else release_block(addr, req);
                end
                KIND_REALLOC: begin
                    if (!fits_small(req == 0 ? 1 : req) || !fits_small(old == 0 ? 1 : old)) begin
                        st = STAT_LARGE;
                    end else begin
                        release_block(addr, old);
                        st = grant_block(req, a);
                    end
                end
                default: ;
            endcase
            g.addr = a[15:0];
            g.status = st;
            owed.push_back(g);
            return g;
        endfunction

        function void check_grant(logic [15:0] addr, logic [1:0] status);
            t_grant g;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result addr=%h status=%0d", $time, addr, status);
                errors++;
                return;
            end
            g = owed.pop_front();
            if (addr !== g.addr) begin
                $display("%0t: result_addr expected %h actual %h", $time, g.addr, addr);
                errors++;
            end
            if (status !== g.status) begin
                $display("%0t: status expected %0d actual %0d", $time, g.status, status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    scfl_in_if  in_ch();
    scfl_out_if out_ch();

    size_class_free_list_allocator_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    alloc_scoreboard sb = new();
    t_block live[$];
    bit     calm;
    bit     sending_done;

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones, none at all during calm stretches
    function int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic [11:0] pick_small();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return 12'd0;
        if (r < 4) return 12'(($urandom_range(1, 16)) * GRAN);
        return 12'($urandom_range(1, SMALL_MAX));
    endfunction

    // present one request, hold it until taken, feed the mirror
    task automatic send_request(logic [1:0] kind, logic [11:0] req,
                                logic [11:0] old, logic [15:0] addr);
        int unsigned gap;
        t_grant g;
        t_block nb;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.req_size   <= req;
        in_ch.old_size   <= old;
        in_ch.block_addr <= addr;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        g = sb.note_request(kind, req, old, addr);
        if ((kind == KIND_ALLOC || kind == KIND_REALLOC) && g.status == STAT_OK) begin
            nb.addr = g.addr;
            nb.size = req;
            live.push_back(nb);
        end
    endtask

    // release a random live block, either by free or by realloc
    task automatic drop_live(bit as_realloc);
        int unsigned idx;
        t_block b;
        idx = $urandom_range(0, live.size() - 1);
        b = live[idx];
        live.delete(idx);
        if (as_realloc) send_request(KIND_REALLOC, pick_small(), b.size, b.addr);
        else send_request(KIND_FREE, b.size, 12'd0, b.addr);
    endtask

    // request stream: directed corners, then mostly well-formed traffic
    initial begin
        int unsigned r;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_ALLOC;
        in_ch.req_size   <= '0;
        in_ch.old_size   <= '0;
        in_ch.block_addr <= '0;
        i_rst_n          <= 1'b0;
        calm = 0;
        sending_done = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(KIND_ALLOC, 12'd0, 12'd0, 16'h0000);
        send_request(KIND_ALLOC, 12'd1, 12'd0, 16'h0000);
        send_request(KIND_ALLOC, 12'd8, 12'd0, 16'h0000);
        send_request(KIND_ALLOC, 12'd9, 12'd0, 16'h0000);
        send_request(KIND_ALLOC, 12'd128, 12'd0, 16'h0000);
        send_request(KIND_ALLOC, 12'd129, 12'd0, 16'h0000);
        send_request(KIND_ALLOC, 12'hFFF, 12'd0, 16'hFFFF);
        send_request(KIND_FREE, 12'd200, 12'd0, 16'h0008);
        send_request(KIND_FREE, 12'd0, 12'd0, 16'h0000);
        send_request(KIND_FREE, 12'd16, 12'd0, 16'h0013);
        send_request(KIND_FREE, 12'd16, 12'd0, 16'hFFF8);
        send_request(KIND_ALLOC, 12'd16, 12'd0, 16'h0000);
        send_request(KIND_REALLOC, 12'd130, 12'd8, 16'h0000);
        send_request(KIND_REALLOC, 12'd8, 12'hFFF, 16'h0000);
        send_request(KIND_REALLOC, 12'd0, 12'd0, 16'h0000);
        send_request(KIND_NONE, 12'hFFF, 12'hFFF, 16'hFFFF);
        while (live.size() > 3) drop_live($urandom_range(0, 1));

        for (int i = 0; i < 1100; i++) begin
            if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 5) begin
                // noise: oversized, odd addresses, unused code, mismatched sizes
                case ($urandom_range(0, 3))
                    0: send_request(2'($urandom_range(0, 2)), 12'($urandom_range(129, 4095)),
                                    12'($urandom), 16'($urandom));
                    1: send_request(KIND_FREE, pick_small(), 12'($urandom), 16'($urandom));
                    2: send_request(KIND_NONE, 12'($urandom), 12'($urandom), 16'($urandom));
                    default: send_request(KIND_REALLOC, pick_small(), 12'($urandom_range(129, 4095)),
                                          16'($urandom));
                endcase
            end else if (live.size() == 0 || r < (i < 650 ? 65 : 45)) begin
                send_request(KIND_ALLOC, pick_small(), 12'($urandom), 16'($urandom));
            end else begin
                drop_live(r > 85);
            end
        end
        in_ch.valid <= 1'b0;
        sending_done = 1;
    end

    // result side: random back-pressure, check every accepted result
    initial begin
        int unsigned stall;
        out_ch.ready <= 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_grant(out_ch.result_addr, out_ch.status);
            if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                stall = pick_gap();
                out_ch.ready <= (stall == 0);
            end
        end
    end

    // wrap-up once every request is in and every grant has come back
    initial begin
        wait (sending_done);
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/scfl_pkg.sv
sv/scfl_in_if.sv
sv/scfl_out_if.sv
sv/scfl_ram.sv
sv/size_class_free_list_allocator_core.sv
bench/size_class_free_list_allocator_core_tb.sv
